// File: design/i32av_pkg.sv
// Shared types, codes and constants for the int32 argument validator.
// Used by every module of the block; depends on nothing.
package i32av_pkg;

   // Store size default and fixed argument rules
   localparam int DEF_MAX_VALUES = 256;
   localparam int MAX_CHARS      = 11;
   localparam logic [3:0] POS_SATURATE = 4'd12;

   // Magnitude limits
   localparam logic [35:0] MAG_CEILING  = 36'd2147483648;
   localparam logic [31:0] LIMIT_POS    = 32'd2147483647;
   localparam logic [31:0] LIMIT_NEG    = 32'd2147483648;

   // Character codes
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Request operation codes
   localparam logic [1:0] OP_CHAR     = 2'd0;
   localparam logic [1:0] OP_END_ARG  = 2'd1;
   localparam logic [1:0] OP_END_LIST = 2'd2;

   // Verdict kinds
   localparam logic KIND_ARG  = 1'b0;
   localparam logic KIND_LIST = 1'b1;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_MALFORMED = 3'd1,
      ST_RANGE     = 3'd2,
      ST_DUP       = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_SCAN,
      B_FIN
   } back_state_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] character;
   } req_type;

   typedef struct packed {
      logic               verdict_kind;
      logic signed [31:0] parsed_value;
      logic [2:0]         arg_status;
      logic               list_ok;
      logic [8:0]         value_count;
   } rsp_type;

   // Classified command handed from front to back
   typedef struct packed {
      logic        kind;
      status_type  status;
      logic [31:0] value;
   } cmd_type;

endpackage

// File: design/i32av_front.sv
// Front part: accepts requests, parses argument text, classifies each argument.
// Depends on i32av_pkg; feeds classified commands to the command queue.
module i32av_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  i32av_pkg::req_type  req_data,
   output logic                cmd_valid,
   input  logic                cmd_ready,
   output i32av_pkg::cmd_type  cmd_data
);

   logic [31:0] mag_ff, mag_in;
   logic        ovf_ff, ovf_in;
   logic        neg_ff, neg_in;
   logic [3:0]  pos_ff, pos_in;
   logic        fzero_ff, fzero_in;
   logic        bad_ff, bad_in;

   logic        take;
   logic        is_digit;
   logic [3:0]  digit;
   logic [35:0] mag_next;
   logic        malformed;
   logic        out_range;
   logic [31:0] limit;

   assign req_ready = cmd_ready;
   assign take      = req_valid && req_ready;

   // Decode the character and build the next magnitude
   assign is_digit = (req_data.character >= i32av_pkg::CHAR_ZERO) &&
                     (req_data.character <= i32av_pkg::CHAR_NINE);
   assign digit    = 4'(req_data.character - i32av_pkg::CHAR_ZERO);
   assign mag_next = ({4'b0, mag_ff} << 3) + ({4'b0, mag_ff} << 1) + 36'(digit);

   // Classify the argument collected so far
   assign limit     = neg_ff ? i32av_pkg::LIMIT_NEG : i32av_pkg::LIMIT_POS;
   assign malformed = (pos_ff == 4'd0) || (pos_ff > 4'(i32av_pkg::MAX_CHARS)) || bad_ff ||
                      (neg_ff && (pos_ff == 4'd1)) ||
                      (fzero_ff && (neg_ff || (pos_ff > 4'd1)));
   assign out_range = ovf_ff || (mag_ff > limit);

   // Form the command for end of argument or end of list
   always_comb begin
      cmd_valid     = req_valid && ((req_data.operation == i32av_pkg::OP_END_ARG) ||
                                    (req_data.operation == i32av_pkg::OP_END_LIST));
      cmd_data.kind = (req_data.operation == i32av_pkg::OP_END_LIST) ?
                      i32av_pkg::KIND_LIST : i32av_pkg::KIND_ARG;
      if (req_data.operation == i32av_pkg::OP_END_LIST) begin
         cmd_data.status = i32av_pkg::ST_OK;
      end else if (malformed) begin
         cmd_data.status = i32av_pkg::ST_MALFORMED;
      end else if (out_range) begin
         cmd_data.status = i32av_pkg::ST_RANGE;
      end else begin
         cmd_data.status = i32av_pkg::ST_OK;
      end
      cmd_data.value = neg_ff ? (32'd0 - mag_ff) : mag_ff;
   end

   // Advance the parse state
   always_comb begin
      mag_in   = mag_ff;
      ovf_in   = ovf_ff;
      neg_in   = neg_ff;
      pos_in   = pos_ff;
      fzero_in = fzero_ff;
      bad_in   = bad_ff;
      if (take) begin
         case (req_data.operation)
            i32av_pkg::OP_CHAR: begin
               if (pos_ff < i32av_pkg::POS_SATURATE) begin
                  pos_in = pos_ff + 4'd1;
               end
               if ((pos_ff == 4'd0) && (req_data.character == i32av_pkg::CHAR_MINUS)) begin
                  neg_in = 1'b1;
               end else if (!is_digit) begin
                  bad_in = 1'b1;
               end else begin
                  if ((req_data.character == i32av_pkg::CHAR_ZERO) &&
                      (((pos_ff == 4'd0) && !neg_ff) || ((pos_ff == 4'd1) && neg_ff))) begin
                     fzero_in = 1'b1;
                  end
                  if (!ovf_ff) begin
                     if (mag_next > i32av_pkg::MAG_CEILING) begin
                        ovf_in = 1'b1;
                     end else begin
                        mag_in = mag_next[31:0];
                     end
                  end
               end
            end
            i32av_pkg::OP_END_ARG, i32av_pkg::OP_END_LIST: begin
               mag_in   = 32'd0;
               ovf_in   = 1'b0;
               neg_in   = 1'b0;
               pos_in   = 4'd0;
               fzero_in = 1'b0;
               bad_in   = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_ff   <= 32'd0;
         ovf_ff   <= 1'b0;
         neg_ff   <= 1'b0;
         pos_ff   <= 4'd0;
         fzero_ff <= 1'b0;
         bad_ff   <= 1'b0;
      end else begin
         mag_ff   <= mag_in;
         ovf_ff   <= ovf_in;
         neg_ff   <= neg_in;
         pos_ff   <= pos_in;
         fzero_ff <= fzero_in;
         bad_ff   <= bad_in;
      end
   end

endmodule

// File: design/i32av_queue.sv
// Short command queue that decouples the parsing front from the store back.
// Depends on i32av_pkg for the command type and depth.
module i32av_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  i32av_pkg::cmd_type  push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output i32av_pkg::cmd_type  pop_data
);

   localparam int AW = i32av_pkg::QUEUE_AW;
   localparam int CW = $clog2(i32av_pkg::QUEUE_DEPTH + 1);

   i32av_pkg::cmd_type entry_ff [i32av_pkg::QUEUE_DEPTH];
   logic [AW-1:0] wr_ff, wr_in;
   logic [AW-1:0] rd_ff, rd_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic          do_push, do_pop;

   assign push_ready = (fill_ff != CW'(i32av_pkg::QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_data   = entry_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers and fill level
   always_comb begin
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      fill_in = fill_ff;
      if (do_push) begin
         wr_in = (wr_ff == AW'(i32av_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == AW'(i32av_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

   // Hold entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

endmodule

// File: design/i32av_back.sv
// Back part: duplicate scan over the value store, store append, verdict register.
// Depends on i32av_pkg; takes commands from the queue, drives the response port.
module i32av_back #(
   parameter int MAX_VALUES = i32av_pkg::DEF_MAX_VALUES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   output logic                cmd_ready,
   input  i32av_pkg::cmd_type  cmd_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output i32av_pkg::rsp_type  rsp_data
);

   localparam int AW = $clog2(MAX_VALUES);
   localparam int CW = $clog2(MAX_VALUES + 1);

   i32av_pkg::back_state_type state_ff, state_in;

   logic [31:0]   store [MAX_VALUES];
   logic [31:0]   rd_data_ff;

   logic [CW-1:0]      count_ff, count_in;
   logic               lerr_ff, lerr_in;
   logic [CW-1:0]      issue_ff, issue_in;
   logic               pend_ff, pend_in;
   logic               dup_ff, dup_in;
   logic [31:0]        value_ff, value_in;
   logic               rsp_valid_ff, rsp_valid_in;
   i32av_pkg::rsp_type rsp_ff, rsp_in;

   logic              slot_free;
   logic              rd_en;
   logic              wr_en;
   logic              fin_ok;
   logic              full;
   logic              scan_done;
   i32av_pkg::status_type fin_status;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign full      = (count_ff == CW'(MAX_VALUES));
   assign scan_done = dup_ff || ((issue_ff == count_ff) && !pend_ff);
   assign fin_status = dup_ff ? i32av_pkg::ST_DUP :
                       (full ? i32av_pkg::ST_FULL : i32av_pkg::ST_OK);
   assign fin_ok    = (fin_status == i32av_pkg::ST_OK);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         i32av_pkg::B_IDLE: begin
            if (cmd_valid && slot_free && (cmd_data.kind == i32av_pkg::KIND_ARG) &&
                (cmd_data.status == i32av_pkg::ST_OK)) begin
               state_in = (count_ff == '0) ? i32av_pkg::B_FIN : i32av_pkg::B_SCAN;
            end
         end
         i32av_pkg::B_SCAN: begin
            if (scan_done) begin
               state_in = i32av_pkg::B_FIN;
            end
         end
         i32av_pkg::B_FIN: begin
            if (slot_free) begin
               state_in = i32av_pkg::B_IDLE;
            end
         end
         default: begin
            state_in = i32av_pkg::B_IDLE;
         end
      endcase
   end

   // Outputs and datapath control
   always_comb begin
      cmd_ready    = 1'b0;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      count_in     = count_ff;
      lerr_in      = lerr_ff;
      issue_in     = issue_ff;
      pend_in      = 1'b0;
      dup_in       = dup_ff;
      value_in     = value_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      case (state_ff)
         i32av_pkg::B_IDLE: begin
            cmd_ready = slot_free;
            if (cmd_valid && slot_free) begin
               value_in = cmd_data.value;
               issue_in = '0;
               dup_in   = 1'b0;
               if (cmd_data.kind == i32av_pkg::KIND_LIST) begin
                  rsp_valid_in          = 1'b1;
                  rsp_in.verdict_kind   = i32av_pkg::KIND_LIST;
                  rsp_in.parsed_value   = 32'sd0;
                  rsp_in.arg_status     = i32av_pkg::ST_OK;
                  rsp_in.list_ok        = !lerr_ff;
                  rsp_in.value_count    = 9'(count_ff);
                  count_in              = '0;
                  lerr_in               = 1'b0;
               end else if (cmd_data.status != i32av_pkg::ST_OK) begin
                  rsp_valid_in          = 1'b1;
                  rsp_in.verdict_kind   = i32av_pkg::KIND_ARG;
                  rsp_in.parsed_value   = 32'sd0;
                  rsp_in.arg_status     = cmd_data.status;
                  rsp_in.list_ok        = 1'b0;
                  rsp_in.value_count    = 9'(count_ff);
                  lerr_in               = 1'b1;
               end
            end
         end
         i32av_pkg::B_SCAN: begin
            // Issue one read a cycle, compare the previous read's data
            if (!dup_ff && (issue_ff < count_ff)) begin
               rd_en    = 1'b1;
               issue_in = issue_ff + 1'b1;
               pend_in  = 1'b1;
            end
            if (pend_ff && (rd_data_ff == value_ff)) begin
               dup_in = 1'b1;
            end
         end
         i32av_pkg::B_FIN: begin
            if (slot_free) begin
               wr_en               = fin_ok;
               rsp_valid_in        = 1'b1;
               rsp_in.verdict_kind = i32av_pkg::KIND_ARG;
               rsp_in.parsed_value = fin_ok ? value_ff : 32'sd0;
               rsp_in.arg_status   = fin_status;
               rsp_in.list_ok      = 1'b0;
               if (fin_ok) begin
                  count_in = count_ff + 1'b1;
               end else begin
                  lerr_in  = 1'b1;
               end
               rsp_in.value_count  = fin_ok ? 9'(count_ff + 1'b1) : 9'(count_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= i32av_pkg::B_IDLE;
         count_ff     <= '0;
         lerr_ff      <= 1'b0;
         issue_ff     <= '0;
         pend_ff      <= 1'b0;
         dup_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         lerr_ff      <= lerr_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         dup_ff       <= dup_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload registers
   always_ff @(posedge clock) begin
      value_ff <= value_in;
      rsp_ff   <= rsp_in;
   end

   // Value store: one registered read port, one write port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store[issue_ff[AW-1:0]];
      end
      if (wr_en) begin
         store[count_ff[AW-1:0]] <= value_ff;
      end
   end

endmodule

// File: design/int32_argument_validator.sv
// Top level of the int32 argument validator: front parser, queue, store back.
// Depends on i32av_pkg, i32av_front, i32av_queue and i32av_back.
//
//   channel | direction | payload              | handshake
//   req     | in        | i32av_pkg::req_type  | req_valid / req_ready
//   rsp     | out       | i32av_pkg::rsp_type  | rsp_valid / rsp_ready
//
// The front takes a character or an ignored operation while the queue has room.
// An end of argument that parses runs the duplicate scan in the back (skipped when the
// store is empty), which reads one stored value per cycle from the single memory
// port.
// Malformed, out-of-range and end-of-list commands get no scan in the back.
// Reset is synchronous and clears all control state; the store needs no clearing.
// The two-entry command queue lets parsing go on while the back scans or stalls.
module int32_argument_validator #(
   parameter int MAX_VALUES = i32av_pkg::DEF_MAX_VALUES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  i32av_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output i32av_pkg::rsp_type  rsp_data
);

   logic               push_valid, push_ready;
   i32av_pkg::cmd_type push_data;
   logic               pop_valid, pop_ready;
   i32av_pkg::cmd_type pop_data;

   // Parse and classify
   i32av_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (push_valid),
      .cmd_ready (push_ready),
      .cmd_data  (push_data)
   );

   // Decouple front and back
   i32av_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Check duplicates, store, respond
   i32av_back #(
      .MAX_VALUES (MAX_VALUES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd_ready (pop_ready),
      .cmd_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
